FILE: rtl/dehb_pkg.sv
// dehb_pkg: shared types and fixed constants of the delay error histogram bound unit
// field widths, operation and register codes, reset values, state encoding
// no dependencies
`timescale 1ns / 1ps

package dehb_pkg;

  localparam int RATE_W     = 18;
  localparam int BOUND_W    = 6;
  localparam int ERR_W      = 24;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;

  // samples to milliseconds
  localparam int MS_SCALE   = 1000;
  localparam int MS_SCALE_W = 10;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd16000;
  localparam logic [BOUND_W-1:0] MIN_RESET   = 6'd8;
  localparam logic [BOUND_W-1:0] BOUND_RESET = 6'd28;
  localparam logic [BOUND_W-1:0] BOUND_MAX   = 6'd63;

  // fewest counts for a bound from the histogram
  localparam int MIN_TOTAL = 5;
  // 5 percent point is total / 20
  localparam int LO_DIV    = 20;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_EVAL  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPTURE_RATE = 1'd0,
    REG_MIN_BOUND    = 1'd1
  } reg_idx_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_IDX   = 8'b0000_0100,
    ST_RD    = 8'b0000_1000,
    ST_INC   = 8'b0001_0000,
    ST_SUM   = 8'b0010_0000,
    ST_SPLIT = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  // walk state shares the split code path, own encoding below
  typedef enum logic [1:0] {
    WK_OFF = 2'b01,
    WK_RUN = 2'b10
  } walk_t;

endpackage

FILE: rtl/delay_error_histogram_bound_unit.sv
// delay_error_histogram_bound_unit: histogram of delay errors and adaptive jump bound
// one module: bit-serial restoring divider, bin memory with valid bits, sequencer
// depends on dehb_pkg
`timescale 1ns / 1ps

// One word in, one word out, one at a time. Add converts the error to a bin with a
// restoring divider that retires one quotient bit per cycle, then reads and writes the
// bin; a zero error skips the divider. Evaluate sums the bins one per cycle, finds the
// 5 percent point with the same divider, then walks the bins one per cycle; it skips
// the divider and the walk when fewer than 5 counts are held. Clear and the unused
// code go straight to the done state, which waits while the previous result is still
// stalled. A new word is taken while the previous result waits on out_stall.
// The bin store reads as zero after reset and after clear through per-bin valid bits.
module delay_error_histogram_bound_unit
  import dehb_pkg::*;
#(
  parameter int NUM_BINS       = 26,
  parameter int HALF_WINDOW_MS = 50,
  parameter int BIN_WIDTH_MS   = 4,
  parameter int COUNT_WIDTH    = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_operation,
  input  logic signed [ERR_W-1:0] in_error_samples,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BOUND_W-1:0]      out_bound_ms,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IW    = $clog2(NUM_BINS);
  localparam int AW    = $clog2(NUM_BINS + 1);
  localparam int TW    = COUNT_WIDTH + $clog2(NUM_BINS);
  localparam int TW1   = TW + 1;
  localparam int N_W   = ERR_W + MS_SCALE_W;
  localparam int DVW   = (N_W > TW) ? N_W : TW;
  localparam int CNTW  = $clog2(DVW);
  localparam int BW_W  = $clog2(BIN_WIDTH_MS + 1);
  localparam int DSW   = RATE_W + BW_W;
  localparam int HB    = HALF_WINDOW_MS / BIN_WIDTH_MS;
  localparam int SW    = $clog2(2 * HB + NUM_BINS + 1);
  localparam int DW    = IW + BW_W + BOUND_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // control
  state_t                state_r, state_nxt;
  logic [NUM_BINS-1:0]   vld_r, vld_nxt;
  logic [BOUND_W-1:0]    bound_r, bound_nxt;
  logic [RATE_W-1:0]     rate_r, rate_nxt;
  logic [BOUND_W-1:0]    min_r, min_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  pv_r, pv_nxt;
  walk_t                 walk_r, walk_nxt;

  // datapath
  logic [BOUND_W-1:0]    out_bound_r, out_bound_nxt;
  logic                  is_add_r, is_add_nxt;
  logic                  neg_r, neg_nxt;
  logic                  sat_r, sat_nxt;
  logic [DVW-1:0]        dvd_r, dvd_nxt;
  logic [DSW-1:0]        dsr_r, dsr_nxt;
  logic [DSW-1:0]        rem_r, rem_nxt;
  logic [TW-1:0]         quo_r, quo_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic [IW-1:0]         widx_r, widx_nxt;
  logic [IW-1:0]         left_r, left_nxt;
  logic [TW-1:0]         total_r, total_nxt;
  logic [TW-1:0]         run_r, run_nxt;
  logic [TW-1:0]         hi_r, hi_nxt;

  // bin store
  logic [COUNT_WIDTH-1:0] bins_mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic                   rd_vld_r;
  logic                   rd_en;
  logic                   mem_we;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  // combinational helpers
  logic                   accept;
  logic [ERR_W-1:0]       mag;
  logic [N_W-1:0]         n_full;
  logic [DSW:0]           r2;
  logic [DSW:0]           rsub;
  logic                   ge;
  logic [TW:0]            qw;
  logic [SW-1:0]          qsel;
  logic [SW-1:0]          idx_sum;
  logic [COUNT_WIDTH-1:0] bin_val;
  logic [TW-1:0]          run_sum;
  logic [IW-1:0]          left_cur;
  logic [IW-1:0]          diff;
  logic [DW-1:0]          span;
  logic [BOUND_W-1:0]     span_sat;
  logic                   issue;
  logic                   out_free;

  assign in_stall     = (state_r != ST_IDLE);
  assign accept       = in_valid && (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_bound_ms = out_bound_r;
  assign out_free     = !out_valid_r || !out_stall;

  assign mag    = in_error_samples[ERR_W-1] ? (~in_error_samples + 1'b1) : in_error_samples;
  assign n_full = N_W'(mag) * N_W'(MS_SCALE);

  // one restoring division step
  assign r2   = {rem_r, dvd_r[DVW-1]};
  assign rsub = r2 - {1'b0, dsr_r};
  assign ge   = (r2 >= {1'b0, dsr_r});
  assign qw   = {quo_r, ge};

  // bin index from the clamped quotient
  assign qsel    = sat_r ? SW'(HB) : SW'(quo_r);
  assign idx_sum = neg_r ? (SW'(HB) - qsel) : (SW'(HB) + qsel);

  assign bin_val  = rd_vld_r ? rd_data_r : '0;
  assign run_sum  = run_r + TW'(bin_val);
  assign left_cur = (run_r <= quo_r) ? widx_r : left_r;
  assign diff     = widx_r - left_cur;
  assign span     = DW'(diff >> 1) * DW'(BIN_WIDTH_MS);
  assign span_sat = (span > DW'(BOUND_MAX)) ? BOUND_MAX : span[BOUND_W-1:0];
  assign issue    = (addr_r < AW'(NUM_BINS));

  always_comb begin
    state_nxt     = state_r;
    vld_nxt       = vld_r;
    bound_nxt     = bound_r;
    rate_nxt      = rate_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r;
    pv_nxt        = pv_r;
    walk_nxt      = walk_r;
    out_bound_nxt = out_bound_r;
    is_add_nxt    = is_add_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    dvd_nxt       = dvd_r;
    dsr_nxt       = dsr_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    widx_nxt      = widx_r;
    left_nxt      = left_r;
    total_nxt     = total_r;
    run_nxt       = run_r;
    hi_nxt        = hi_r;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = bin_val;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPTURE_RATE: rate_nxt = cfg_wdata[RATE_W-1:0];
        REG_MIN_BOUND:    min_nxt  = cfg_wdata[BOUND_W-1:0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_ADD: begin
              is_add_nxt = 1'b1;
              neg_nxt    = in_error_samples[ERR_W-1];
              dvd_nxt    = DVW'(n_full);
              dsr_nxt    = DSW'(rate_r) * DSW'(BIN_WIDTH_MS);
              rem_nxt    = '0;
              quo_nxt    = '0;
              sat_nxt    = 1'b0;
              cnt_nxt    = '0;
              state_nxt  = (mag == '0) ? ST_IDX : ST_DIV;
            end
            OP_EVAL: begin
              bound_nxt = min_r;
              addr_nxt  = '0;
              pv_nxt    = 1'b0;
              total_nxt = '0;
              state_nxt = ST_SUM;
            end
            OP_CLEAR: begin
              vld_nxt   = '0;
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? rsub[DSW-1:0] : r2[DSW-1:0];
        dvd_nxt = {dvd_r[DVW-2:0], 1'b0};
        cnt_nxt = cnt_r + CNTW'(1);
        if (is_add_r) begin
          if (sat_r || (qw > TW1'(HB))) begin
            sat_nxt = 1'b1;
          end else begin
            quo_nxt = qw[TW-1:0];
          end
        end else begin
          quo_nxt = qw[TW-1:0];
        end
        if (cnt_r == CNTW'(DVW - 1)) begin
          state_nxt = is_add_r ? ST_IDX : ST_SPLIT;
        end
      end
      ST_IDX: begin
        if (idx_sum > SW'(NUM_BINS - 1)) begin
          addr_nxt = AW'(NUM_BINS - 1);
        end else begin
          addr_nxt = AW'(idx_sum);
        end
        state_nxt = ST_RD;
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_INC;
      end
      ST_INC: begin
        mem_we    = 1'b1;
        mem_wdata = (bin_val == COUNT_MAX) ? bin_val : (bin_val + COUNT_WIDTH'(1));
        vld_nxt[addr_r[IW-1:0]] = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SUM: begin
        if (pv_r) begin
          total_nxt = total_r + TW'(bin_val);
        end
        if (issue) begin
          rd_en    = 1'b1;
          addr_nxt = addr_r + AW'(1);
          pv_nxt   = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (!issue && !pv_r) begin
          if (total_r < TW'(MIN_TOTAL)) begin
            state_nxt = ST_DONE;
          end else begin
            is_add_nxt = 1'b0;
            dvd_nxt    = DVW'(total_r);
            dsr_nxt    = DSW'(LO_DIV);
            rem_nxt    = '0;
            quo_nxt    = '0;
            sat_nxt    = 1'b0;
            cnt_nxt    = '0;
            state_nxt  = ST_DIV;
          end
        end
      end
      ST_SPLIT: begin
        unique case (walk_r)
          WK_OFF: begin
            // 95 percent point is total minus the rounded-up 5 percent share
            hi_nxt   = total_r - quo_r - TW'(rem_r != '0);
            run_nxt  = '0;
            left_nxt = '0;
            widx_nxt = '0;
            addr_nxt = '0;
            pv_nxt   = 1'b0;
            walk_nxt = WK_RUN;
          end
          WK_RUN: begin
            if (pv_r) begin
              run_nxt  = run_sum;
              left_nxt = left_cur;
              widx_nxt = widx_r + IW'(1);
            end
            if (issue) begin
              rd_en    = 1'b1;
              addr_nxt = addr_r + AW'(1);
              pv_nxt   = 1'b1;
            end else begin
              pv_nxt = 1'b0;
            end
            if (pv_r && (run_sum >= hi_r)) begin
              if (span_sat > min_r) begin
                bound_nxt = span_sat;
              end
              walk_nxt  = WK_OFF;
              state_nxt = ST_DONE;
            end else if (!issue && !pv_r) begin
              walk_nxt  = WK_OFF;
              state_nxt = ST_DONE;
            end
          end
          default: begin
            walk_nxt = WK_OFF;
          end
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bound_nxt = bound_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      bound_r     <= BOUND_RESET;
      rate_r      <= RATE_RESET;
      min_r       <= MIN_RESET;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      walk_r      <= WK_OFF;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      bound_r     <= bound_nxt;
      rate_r      <= rate_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
      walk_r      <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bound_r <= out_bound_nxt;
    is_add_r    <= is_add_nxt;
    neg_r       <= neg_nxt;
    sat_r       <= sat_nxt;
    dvd_r       <= dvd_nxt;
    dsr_r       <= dsr_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    addr_r      <= addr_nxt;
    widx_r      <= widx_nxt;
    left_r      <= left_nxt;
    total_r     <= total_nxt;
    run_r       <= run_nxt;
    hi_r        <= hi_nxt;
  end

  // bin store, one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= bins_mem[addr_r[IW-1:0]];
      rd_vld_r  <= vld_r[addr_r[IW-1:0]];
    end
    if (mem_we) begin
      bins_mem[addr_r[IW-1:0]] <= mem_wdata;
    end
  end

endmodule
